// ===== src/tds_pkg.sv =====
// types, constants and the threshold ladder for the timer divider select block
package tds_pkg;

    localparam int unsigned DIV_STAGES = 32;
    localparam logic [31:0] LEVEL      = 32'h0000_FFFF;
    localparam logic [31:0] BUS_CLOCK_RESET = 32'd60_000_000;

    // reciprocal of ten, exact for counts below 2^22
    localparam int unsigned RECIP_SHIFT = 25;
    localparam logic [21:0] RECIP_TEN   = 22'd3_355_444;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ABOVE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_LOW   = 2'd3;

    localparam logic [1:0] MUL_NONE = 2'd0;

    localparam logic REG_BUS_CLOCK = 1'b0;

    localparam int unsigned NUM_RUNGS = 16;

    typedef struct packed {
        logic [31:0] limit;
        logic [2:0]  pre;
        logic [1:0]  mul;
    } t_rung;

    // ordered ladder, first rung whose limit exceeds the count wins
    function automatic t_rung ladder_rung(input logic [3:0] idx);
        t_rung r;
        unique case (idx)
            4'd0:  r = '{limit: 32'(32'd2    * LEVEL), pre: 3'd1, mul: 2'd0};
            4'd1:  r = '{limit: 32'(32'd4    * LEVEL), pre: 3'd2, mul: 2'd0};
            4'd2:  r = '{limit: 32'(32'd8    * LEVEL), pre: 3'd3, mul: 2'd0};
            4'd3:  r = '{limit: 32'(32'd10   * LEVEL), pre: 3'd0, mul: 2'd1};
            4'd4:  r = '{limit: 32'(32'd16   * LEVEL), pre: 3'd4, mul: 2'd0};
            4'd5:  r = '{limit: 32'(32'd20   * LEVEL), pre: 3'd0, mul: 2'd2};
            4'd6:  r = '{limit: 32'(32'd32   * LEVEL), pre: 3'd5, mul: 2'd0};
            4'd7:  r = '{limit: 32'(32'd40   * LEVEL), pre: 3'd0, mul: 2'd3};
            4'd8:  r = '{limit: 32'(32'd64   * LEVEL), pre: 3'd6, mul: 2'd0};
            4'd9:  r = '{limit: 32'(32'd128  * LEVEL), pre: 3'd7, mul: 2'd0};
            4'd10: r = '{limit: 32'(32'd160  * LEVEL), pre: 3'd4, mul: 2'd1};
            4'd11: r = '{limit: 32'(32'd320  * LEVEL), pre: 3'd4, mul: 2'd2};
            4'd12: r = '{limit: 32'(32'd640  * LEVEL), pre: 3'd4, mul: 2'd3};
            4'd13: r = '{limit: 32'(32'd1280 * LEVEL), pre: 3'd5, mul: 2'd3};
            4'd14: r = '{limit: 32'(32'd2560 * LEVEL), pre: 3'd6, mul: 2'd3};
            4'd15: r = '{limit: 32'(32'd5120 * LEVEL), pre: 3'd7, mul: 2'd3};
            default: r = '{limit: 32'd0, pre: 3'd0, mul: 2'd0};
        endcase
        return r;
    endfunction

endpackage

// ===== src/timer_divider_select.sv =====
// timer divider select: pipelined divide, ladder search and modulus scaling
// an item passes the input register, the divider stages, the ladder, reciprocal and output registers
// throughput: one item per cycle while the output is not stalled, set by the 32-stage one-bit-per-stage divider
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset (synchronous, active low) empties the pipeline and loads bus clock 60000000
module timer_divider_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_rate_hz,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_prescale_code,
    output logic [1:0]  o_mult_code,
    output logic [15:0] o_modulus,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NS = tds_pkg::DIV_STAGES;
    localparam logic [1:0] ADDR_BUS_CLOCK = 2'(4 * tds_pkg::REG_BUS_CLOCK);

    logic [31:0] r_bus_clock;
    logic        w_adv;

    // divider stages, index 0 is the input register
    logic        r_vld [0:NS];
    logic [1:0]  r_st  [0:NS];
    logic [31:0] r_dvd [0:NS];
    logic [31:0] r_div [0:NS];
    logic [31:0] r_rem [0:NS];
    logic [31:0] r_quo [0:NS];

    logic        r_p1_vld;
    logic [1:0]  r_p1_st;
    logic [2:0]  r_p1_pre;
    logic [1:0]  r_p1_mul;
    logic [21:0] r_p1_cnt;

    logic        r_p2_vld;
    logic [1:0]  r_p2_st;
    logic [2:0]  r_p2_pre;
    logic [1:0]  r_p2_mul;
    logic [15:0] r_p2_cnt;
    logic [43:0] r_p2_prod;

    logic        r_out_vld;
    logic [2:0]  r_out_pre;
    logic [1:0]  r_out_mul;
    logic [15:0] r_out_mod;
    logic [1:0]  r_out_st;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUS_CLOCK) ? r_bus_clock : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_clock <= tds_pkg::BUS_CLOCK_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_BUS_CLOCK)) begin
            r_bus_clock <= pwdata;
        end
    end

    // input stage: range checks
    logic [1:0] w_in_st;
    always_comb begin
        priority if (i_rate_hz > r_bus_clock) begin
            w_in_st = tds_pkg::ST_ABOVE;
        end else if (i_rate_hz == 32'd0) begin
            w_in_st = tds_pkg::ST_ZERO;
        end else begin
            w_in_st = tds_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0]  <= w_in_st;
            r_dvd[0] <= r_bus_clock;
            r_div[0] <= i_rate_hz;
            r_rem[0] <= 32'd0;
            r_quo[0] <= 32'd0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [32:0] w_shift;
        logic [32:0] w_diff;
        logic        w_bit;

        assign w_shift = {r_rem[k], r_dvd[k][31]};
        assign w_diff  = w_shift - {1'b0, r_div[k]};
        assign w_bit   = (w_shift >= {1'b0, r_div[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[k+1]  <= r_st[k];
                r_dvd[k+1] <= {r_dvd[k][30:0], 1'b0};
                r_div[k+1] <= r_div[k];
                r_rem[k+1] <= w_bit ? w_diff[31:0] : w_shift[31:0];
                r_quo[k+1] <= {r_quo[k][30:0], w_bit};
            end
        end
    end

    // ladder search and prescale shift
    logic [31:0]         w_cnt;
    logic                w_big;
    logic                w_found;
    tds_pkg::t_rung      w_rung;
    tds_pkg::t_rung      w_sel;
    logic [31:0]         w_shifted;
    logic [1:0]          w_p1_st;
    logic [2:0]          w_p1_pre;
    logic [1:0]          w_p1_mul;

    always_comb begin
        w_cnt   = r_quo[NS];
        w_big   = (w_cnt > tds_pkg::LEVEL);
        w_found = 1'b0;
        w_sel   = '{limit: 32'd0, pre: 3'd0, mul: 2'd0};
        w_rung  = '{limit: 32'd0, pre: 3'd0, mul: 2'd0};
        // walk from the top so the lowest matching rung wins
        for (int i = tds_pkg::NUM_RUNGS - 1; i >= 0; i--) begin
            w_rung = tds_pkg::ladder_rung(4'(i));
            if (w_cnt < w_rung.limit) begin
                w_sel   = w_rung;
                w_found = 1'b1;
            end
        end
        w_p1_st  = r_st[NS];
        w_p1_pre = 3'd0;
        w_p1_mul = tds_pkg::MUL_NONE;
        if ((r_st[NS] == tds_pkg::ST_OK) && w_big) begin
            if (w_found) begin
                w_p1_pre = w_sel.pre;
                w_p1_mul = w_sel.mul;
            end else begin
                w_p1_st = tds_pkg::ST_LOW;
            end
        end
        w_shifted = w_cnt >> w_p1_pre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_adv) begin
            r_p1_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_st  <= w_p1_st;
            r_p1_pre <= w_p1_pre;
            r_p1_mul <= w_p1_mul;
            r_p1_cnt <= w_shifted[21:0];
        end
    end

    // divide by ten through the reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_adv) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2_st   <= r_p1_st;
            r_p2_pre  <= r_p1_pre;
            r_p2_mul  <= r_p1_mul;
            r_p2_cnt  <= r_p1_cnt[15:0];
            r_p2_prod <= 44'(r_p1_cnt) * 44'(tds_pkg::RECIP_TEN);
        end
    end

    // multiplier shift and modulus
    logic [18:0] w_tenth;
    logic [18:0] w_scaled;
    logic [15:0] w_final;
    logic [1:0]  w_mshift;

    always_comb begin
        w_tenth  = r_p2_prod[tds_pkg::RECIP_SHIFT +: 19];
        w_mshift = r_p2_mul - 2'd1;
        w_scaled = w_tenth >> w_mshift;
        w_final  = (r_p2_mul != tds_pkg::MUL_NONE) ? w_scaled[15:0] : r_p2_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_st <= r_p2_st;
            if (r_p2_st == tds_pkg::ST_OK) begin
                r_out_pre <= r_p2_pre;
                r_out_mul <= r_p2_mul;
                r_out_mod <= w_final - 16'd1;
            end else begin
                r_out_pre <= 3'd0;
                r_out_mul <= tds_pkg::MUL_NONE;
                r_out_mod <= 16'd0;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_prescale_code = r_out_pre;
    assign o_mult_code     = r_out_mul;
    assign o_modulus       = r_out_mod;
    assign o_status        = r_out_st;

`ifndef SYNTH
    // every item that failed a range check leaves with cleared settings
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_st != tds_pkg::ST_OK)) |->
        (r_out_pre == 3'd0 && r_out_mul == tds_pkg::MUL_NONE && r_out_mod == 16'd0))
        else $error("failed item carries nonzero settings");

    // the final divider remainder is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && (r_st[NS] == tds_pkg::ST_OK)) |-> (r_rem[NS] < r_div[NS]))
        else $error("divider remainder out of range");

    // a decade multiplier only pairs with no prescale or a prescale of four or more
    a_mul_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_mul != tds_pkg::MUL_NONE)) |->
        (r_out_pre == 3'd0 || r_out_pre >= 3'd4))
        else $error("illegal prescale and multiplier pair");

    // a stalled output freezes the last divider valid bit and the ladder stage valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> ($stable(r_vld[NS]) && $stable(r_p1_vld)))
        else $error("pipeline moved while stalled");
`endif

endmodule
